[hw/rtl/brbd_pkg.sv]
// ----------------------------------------------------------------------------
// Balanced row block dispenser package
// Shared constants, word types, controller/datapath bundles and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package brbd_pkg;

    localparam int INDEX_BITS        = 32;
    localparam int MAX_THREADS       = 64;
    localparam int BLOCKS_PER_THREAD = 8;
    localparam int MAX_BLOCKS        = BLOCKS_PER_THREAD * MAX_THREADS;

    // Thread count register width, block index width and step counter width.
    localparam int TC_W  = 7;
    localparam int BLK_W = $clog2(MAX_BLOCKS + 1);
    localparam int CNT_W = $clog2(INDEX_BITS);

    localparam logic [BLK_W-1:0] EXHAUSTED = BLK_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(INDEX_BITS - 1);

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [INDEX_BITS-1:0] range_i_begin;
        logic [INDEX_BITS-1:0] range_i_end;
        logic [INDEX_BITS-1:0] range_j_begin;
        logic [INDEX_BITS-1:0] range_j_end;
    } t_in_word;

    typedef struct packed {
        logic                  has_work;
        logic [INDEX_BITS-1:0] block_i_begin;
        logic [INDEX_BITS-1:0] block_i_end;
        logic [INDEX_BITS-1:0] block_j_begin;
        logic [INDEX_BITS-1:0] block_j_end;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic sum;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_status;

    // Number of row blocks for a thread count: one for a count of zero or one,
    // otherwise eight per thread with the count clipped to the maximum.
    function automatic logic [BLK_W-1:0] f_block_count(input logic [TC_W-1:0] tc);
        logic [TC_W-1:0] t;
        t = tc;
        if (tc > TC_W'(MAX_THREADS)) begin
            t = TC_W'(MAX_THREADS);
        end
        if (tc <= TC_W'(1)) begin
            return BLK_W'(1);
        end
        return BLK_W'(t) * BLK_W'(BLOCKS_PER_THREAD);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/brbd_in_if.sv]
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one load or request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface brbd_in_if;
    logic               valid;
    logic               ready;
    brbd_pkg::t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/brbd_out_if.sv]
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel carrying one dispensed block word.
// ----------------------------------------------------------------------------
`default_nettype none

interface brbd_out_if;
    logic                valid;
    logic                ready;
    brbd_pkg::t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/balanced_row_block_dispenser.sv]
// ----------------------------------------------------------------------------
// Balanced row block dispenser
// Hands out balanced row blocks of a loaded range to worker threads.
// ----------------------------------------------------------------------------
// A load word stores a row and column range and splits the rows into d blocks
// (d = 1 for zero or one thread, else 8 per thread); a request word returns the next
// block with the whole column range, or has_work = 0 once all blocks are out.
// One word is handled at a time. A load runs the serial divider, which works
// out rows per block and leftover rows at one quotient bit per cycle. A
// request steps through multiply, add and output, and holds in output while
// the previous word still waits to be taken. Loads give no output word.
`default_nettype none

module balanced_row_block_dispenser (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [brbd_pkg::TC_W-1:0] i_cfg_wdata,
    brbd_in_if.sink                        i_in,
    brbd_out_if.source                     o_out
);

    brbd_pkg::t_cmd    w_cmd;
    brbd_pkg::t_status w_status;
    logic              w_in_ready;

    assign i_in.ready = w_in_ready;

    brbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.payload.action),
        .i_status    (w_status),
        .o_in_ready  (w_in_ready),
        .o_cmd       (w_cmd)
    );

    brbd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in.payload),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

[hw/rtl/brbd_ctrl.sv]
// ----------------------------------------------------------------------------
// Dispenser controller
// Sequences the datapath through load/divide and request/issue steps.
// ----------------------------------------------------------------------------
`default_nettype none

module brbd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_action,
    input  brbd_pkg::t_status      i_status,
    output logic                   o_in_ready,
    output brbd_pkg::t_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SUM  = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_action == brbd_pkg::ACT_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DIV;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_PUSH;
            end
            S_PUSH: begin
                // Wait here while the previous word still sits unread.
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_starts_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load |=> r_state == S_DIV))
        else $error("load did not start the divider");

endmodule

`default_nettype wire

[hw/rtl/brbd_datapath.sv]
// ----------------------------------------------------------------------------
// Dispenser datapath
// Range registers, serial divider, block address multiply and output word.
// ----------------------------------------------------------------------------
`default_nettype none

module brbd_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [brbd_pkg::TC_W-1:0]        i_cfg_wdata,
    input  brbd_pkg::t_in_word                    i_in_word,
    input  brbd_pkg::t_cmd                        i_cmd,
    output brbd_pkg::t_status                     o_status,
    brbd_out_if.source                            o_out
);

    localparam int IW = brbd_pkg::INDEX_BITS;
    localparam int BW = brbd_pkg::BLK_W;

    logic [brbd_pkg::TC_W-1:0]  r_thread_count;
    logic [BW-1:0]              r_next;
    logic [BW-1:0]              r_div;
    logic [BW-1:0]              r_rem;     // remainder, holds extra_rows when done
    logic [IW-1:0]              r_rpb;     // dividend/quotient, holds rows_per_block
    logic [brbd_pkg::CNT_W-1:0] r_cnt;
    logic [IW-1:0]              r_base;
    logic [IW-1:0]              r_col_b;
    logic [IW-1:0]              r_col_e;
    logic [IW-1:0]              r_prod;
    logic [IW-1:0]              r_beg;
    logic                       r_hit;
    logic                       r_work;
    logic                       r_out_valid;
    brbd_pkg::t_out_word        r_out_word;

    logic [BW-1:0]    w_blocks;
    logic [IW-1:0]    w_range;
    logic [BW:0]      w_rem_sh;
    logic [BW:0]      w_trial;
    logic             w_hit;
    logic [IW-1:0]    w_mult;
    logic [IW+BW-1:0] w_prod;
    logic [IW-1:0]    w_end;

    assign w_blocks = brbd_pkg::f_block_count(r_thread_count);
    assign w_range  = (i_in_word.range_i_end >= i_in_word.range_i_begin) ?
                      (i_in_word.range_i_end - i_in_word.range_i_begin) : '0;

    // Restoring division step; the remainder stays below the divisor, so a
    // set top bit of the trial difference means it went negative.
    assign w_rem_sh = {r_rem, r_rpb[IW-1]};
    assign w_trial  = w_rem_sh - {1'b0, r_div};

    assign w_hit  = (r_next < r_rem);
    assign w_mult = r_rpb + IW'(w_hit);
    assign w_prod = r_next * w_mult;
    assign w_end  = r_beg + r_rpb + IW'(r_hit);

    assign o_status.div_last = (r_cnt == brbd_pkg::DIV_LAST);
    assign o_status.out_free = !r_out_valid || o_out.ready;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thread_count <= brbd_pkg::TC_W'(1);
            r_next         <= brbd_pkg::EXHAUSTED;
            r_rem          <= '0;
            r_rpb          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thread_count <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_rpb  <= w_range;
                r_rem  <= '0;
                r_next <= '0;
            end
            if (i_cmd.div_step) begin
                if (!w_trial[BW]) begin
                    r_rem <= w_trial[BW-1:0];
                end else begin
                    r_rem <= w_rem_sh[BW-1:0];
                end
                r_rpb <= {r_rpb[IW-2:0], !w_trial[BW]};
            end
            if (i_cmd.mul) begin
                r_next <= (r_next < w_blocks) ? (r_next + BW'(1)) : brbd_pkg::EXHAUSTED;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base  <= i_in_word.range_i_begin;
            r_col_b <= i_in_word.range_j_begin;
            r_col_e <= i_in_word.range_j_end;
            r_div   <= w_blocks;
            r_cnt   <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + brbd_pkg::CNT_W'(1);
        end
        if (i_cmd.mul) begin
            r_work <= (r_next < w_blocks);
            r_hit  <= w_hit;
            r_prod <= w_prod[IW-1:0];
        end
        if (i_cmd.sum) begin
            r_beg <= r_base + r_prod + (r_hit ? '0 : IW'(r_rem));
        end
        if (i_cmd.push) begin
            r_out_word.has_work      <= r_work;
            r_out_word.block_i_begin <= r_work ? r_beg : '0;
            r_out_word.block_i_end   <= r_work ? w_end : '0;
            r_out_word.block_j_begin <= r_work ? r_col_b : '0;
            r_out_word.block_j_end   <= r_work ? r_col_e : '0;
        end
    end

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step |-> r_rem < r_div))
        else $error("divider remainder reached the divisor");

    a_next_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next <= brbd_pkg::EXHAUSTED))
        else $error("block counter beyond the exhausted mark");

    a_push_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push |=> r_out_valid))
        else $error("issued word not presented");

endmodule

`default_nettype wire
